[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, held off while reset is asserted.
`define CHK_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("h264rtp: assertion failed");

// Concurrent assertion checked in every cycle, reset included.
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("h264rtp: assertion failed");

`endif

[hw/rtl/h264rtp_pkg.sv]
// Types and constants of the H.264 NAL to RTP packetizer.
// No dependencies; used by the interfaces, the core and the checker.
package h264rtp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 21;
  localparam int unsigned MAXP_W  = 11;
  localparam int unsigned STEP_W  = 17;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TS_W    = 32;

  localparam logic [LEN_W-1:0] MAX_NAL_BYTES = LEN_W'(1048576);

  localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST    = MAXP_W'(1400);
  localparam logic [STEP_W-1:0] TIMESTAMP_STEP_RST = STEP_W'(3600);

  // NAL header fields
  localparam logic [BYTE_W-1:0] NRI_MASK       = 8'hE0;
  localparam logic [BYTE_W-1:0] TYPE_MASK      = 8'h1F;
  localparam logic [BYTE_W-1:0] FU_A_TYPE      = 8'd28;
  localparam logic [BYTE_W-1:0] FU_START_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] FU_END_BIT     = 8'h40;
  localparam logic [4:0]        NAL_TYPE_SPS   = 5'd7;
  localparam logic [4:0]        NAL_TYPE_PPS   = 5'd8;

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned MAX_RESULTS = 3;

  typedef enum logic [0:0] {
    REG_MAX_PAYLOAD    = 1'b0,
    REG_TIMESTAMP_STEP = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              nal_first;
    logic [LEN_W-1:0]  nal_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              packet_first;
    logic              packet_last;
    logic [SEQ_W-1:0]  seq_number;
    logic [TS_W-1:0]   time_stamp;
  } out_item_t;

  typedef struct packed {
    cfg_reg_e          index;
    logic [STEP_W-1:0] data;
  } cfg_req_t;

endpackage

[hw/rtl/h264rtp_nal_if.sv]
// Input channel: NAL bytes with valid/ready.
// Depends on h264rtp_pkg.
interface h264rtp_nal_if;
  logic                  valid;
  logic                  ready;
  h264rtp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/h264rtp_pkt_if.sv]
// Output channel: RTP payload bytes with valid/ready.
// Depends on h264rtp_pkg.
interface h264rtp_pkt_if;
  logic                   valid;
  logic                   ready;
  h264rtp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/h264rtp_cfg_if.sv]
// Configuration write channel: register index and data with valid/ready.
// Depends on h264rtp_pkg.
interface h264rtp_cfg_if;
  logic                  valid;
  logic                  ready;
  h264rtp_pkg::cfg_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/h264_nal_rtp_packetizer_core.sv]
// Channel  | Dir | Payload                                   | Request taken when
// nal_i    | in  | data_byte, nal_first, nal_length          | valid & ready
// pkt_o    | out | payload_byte, packet_first/last, seq, ts  | valid & ready
// cfg_i    | in  | index, data                               | valid & ready (always ready)
//
// One NAL byte per cycle in and one payload byte per cycle out while the output
// is ready. The first body byte of each FU-A fragment yields three bytes, so
// the input stalls there until the four-entry result queue has room for three.
// Input requests are registered, then their results in the queue that drives the output.
// Reset (rst_ni low, async) clears state, queue and config to defaults.
// Output stalls back up through the queue into the input register.
// Depends on h264rtp_pkg and the three channel interfaces.
module h264_nal_rtp_packetizer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  h264rtp_nal_if.sink    nal_i,
  h264rtp_pkt_if.source  pkt_o,
  h264rtp_cfg_if.sink    cfg_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [h264rtp_pkg::MAXP_W-1:0] max_payload_q;
  logic [h264rtp_pkg::STEP_W-1:0] ts_step_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= h264rtp_pkg::MAX_PAYLOAD_RST;
      ts_step_q     <= h264rtp_pkg::TIMESTAMP_STEP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        h264rtp_pkg::REG_MAX_PAYLOAD: begin
          max_payload_q <= cfg_i.payload.data[h264rtp_pkg::MAXP_W-1:0];
        end
        h264rtp_pkg::REG_TIMESTAMP_STEP: begin
          ts_step_q <= cfg_i.payload.data;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------
  logic                  stg_valid_q;
  h264rtp_pkg::in_item_t stg_q;
  logic                  fire;

  assign nal_i.ready = !stg_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (nal_i.ready) begin
      stg_valid_q <= nal_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nal_i.valid && nal_i.ready) begin
      stg_q <= nal_i.payload;
    end
  end

  // ---------------------------------------------------------------------
  // Packetizer state
  // ---------------------------------------------------------------------
  logic [h264rtp_pkg::LEN_W-1:0]  bytes_left_q, bytes_left_d;
  logic [h264rtp_pkg::MAXP_W-1:0] fill_q, fill_d;
  logic [h264rtp_pkg::BYTE_W-1:0] header_q, header_d;
  logic                           frag_q, frag_d;
  logic                           first_frag_q, first_frag_d;
  logic [h264rtp_pkg::SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [h264rtp_pkg::TS_W-1:0]   stamp_q, stamp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      fill_q       <= '0;
      header_q     <= '0;
      frag_q       <= 1'b0;
      first_frag_q <= 1'b0;
      next_seq_q   <= '0;
      stamp_q      <= '0;
    end else if (fire) begin
      bytes_left_q <= bytes_left_d;
      fill_q       <= fill_d;
      header_q     <= header_d;
      frag_q       <= frag_d;
      first_frag_q <= first_frag_d;
      next_seq_q   <= next_seq_d;
      stamp_q      <= stamp_d;
    end
  end

  // SPS and PPS sent as single packets do not advance the timestamp
  function automatic logic is_param_set(input logic [h264rtp_pkg::BYTE_W-1:0] hdr);
    logic [4:0] t;
    t = hdr[4:0];
    return (t == h264rtp_pkg::NAL_TYPE_SPS) || (t == h264rtp_pkg::NAL_TYPE_PPS);
  endfunction

  function automatic h264rtp_pkg::out_item_t mk_res(
    input logic [h264rtp_pkg::BYTE_W-1:0] b,
    input logic                           pf,
    input logic                           pl,
    input logic [h264rtp_pkg::SEQ_W-1:0]  seq,
    input logic [h264rtp_pkg::TS_W-1:0]   ts
  );
    h264rtp_pkg::out_item_t r;
    r.payload_byte = b;
    r.packet_first = pf;
    r.packet_last  = pl;
    r.seq_number   = seq;
    r.time_stamp   = ts;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Per-byte packetizing logic: state update and up to three results
  // ---------------------------------------------------------------------
  h264rtp_pkg::out_item_t         res [h264rtp_pkg::MAX_RESULTS];
  logic [1:0]                     n_res;
  logic [h264rtp_pkg::MAXP_W-1:0] maxp;
  logic [h264rtp_pkg::LEN_W-1:0]  len;
  logic [h264rtp_pkg::SEQ_W-1:0]  seq_out;
  logic [h264rtp_pkg::TS_W-1:0]   stamp_adv;
  logic [h264rtp_pkg::MAXP_W-1:0] fill_inc;
  logic [h264rtp_pkg::BYTE_W-1:0] fu_hdr;
  logic                           open_pkt;
  logic                           frag_last;

  always_comb begin
    bytes_left_d = bytes_left_q;
    fill_d       = fill_q;
    header_d     = header_q;
    frag_d       = frag_q;
    first_frag_d = first_frag_q;
    next_seq_d   = next_seq_q;
    stamp_d      = stamp_q;
    n_res        = 2'd0;
    maxp         = (max_payload_q == '0) ? h264rtp_pkg::MAXP_W'(1) : max_payload_q;
    stamp_adv    = stamp_q + h264rtp_pkg::TS_W'(ts_step_q);
    fill_inc     = fill_q + h264rtp_pkg::MAXP_W'(1);
    fu_hdr       = '0;
    frag_last    = 1'b0;
    open_pkt     = (bytes_left_q != '0) && (!frag_q || (fill_q != '0));
    len          = stg_q.nal_length;
    seq_out      = next_seq_q;
    for (int k = 0; k < h264rtp_pkg::MAX_RESULTS; k++) begin
      res[k] = mk_res(stg_q.data_byte, 1'b0, 1'b0, next_seq_q, stamp_q);
    end

    if (stg_q.nal_first) begin
      // a restart closes a packet that was left open
      seq_out = next_seq_q + h264rtp_pkg::SEQ_W'(open_pkt);
      if (len == '0) begin
        len = h264rtp_pkg::LEN_W'(1);
      end
      if (len > h264rtp_pkg::MAX_NAL_BYTES) begin
        len = h264rtp_pkg::MAX_NAL_BYTES;
      end
      header_d     = stg_q.data_byte;
      fill_d       = '0;
      bytes_left_d = len - h264rtp_pkg::LEN_W'(1);
      next_seq_d   = seq_out;
      if (len <= h264rtp_pkg::LEN_W'(maxp)) begin
        // single NAL packet
        frag_d       = 1'b0;
        first_frag_d = 1'b0;
        res[0]       = mk_res(stg_q.data_byte, 1'b1, bytes_left_d == '0, seq_out, stamp_q);
        n_res        = 2'd1;
        if (bytes_left_d == '0) begin
          next_seq_d = seq_out + h264rtp_pkg::SEQ_W'(1);
          if (!is_param_set(stg_q.data_byte)) begin
            stamp_d = stamp_adv;
          end
        end
      end else begin
        // header byte consumed; body goes out as FU-A
        frag_d       = 1'b1;
        first_frag_d = 1'b1;
      end
    end else if (bytes_left_q != '0) begin
      bytes_left_d = bytes_left_q - h264rtp_pkg::LEN_W'(1);
      if (!frag_q) begin
        res[0] = mk_res(stg_q.data_byte, 1'b0, bytes_left_d == '0, next_seq_q, stamp_q);
        n_res  = 2'd1;
        if (bytes_left_d == '0) begin
          next_seq_d = next_seq_q + h264rtp_pkg::SEQ_W'(1);
          if (!is_param_set(header_q)) begin
            stamp_d = stamp_adv;
          end
        end
      end else begin
        frag_last = (fill_inc >= maxp) || (bytes_left_d == '0);
        if (fill_q == '0) begin
          // FU indicator, FU header, then the body byte
          fu_hdr = header_q & h264rtp_pkg::TYPE_MASK;
          if (first_frag_q) begin
            fu_hdr = fu_hdr | h264rtp_pkg::FU_START_BIT;
          end
          if (bytes_left_q <= h264rtp_pkg::LEN_W'(maxp)) begin
            fu_hdr = fu_hdr | h264rtp_pkg::FU_END_BIT;
          end
          first_frag_d = 1'b0;
          res[0] = mk_res((header_q & h264rtp_pkg::NRI_MASK) | h264rtp_pkg::FU_A_TYPE,
                          1'b1, 1'b0, next_seq_q, stamp_q);
          res[1] = mk_res(fu_hdr, 1'b0, 1'b0, next_seq_q, stamp_q);
          res[2] = mk_res(stg_q.data_byte, 1'b0, frag_last, next_seq_q, stamp_q);
          n_res  = 2'd3;
        end else begin
          res[0] = mk_res(stg_q.data_byte, 1'b0, frag_last, next_seq_q, stamp_q);
          n_res  = 2'd1;
        end
        fill_d = frag_last ? '0 : fill_inc;
        if (frag_last) begin
          next_seq_d = next_seq_q + h264rtp_pkg::SEQ_W'(1);
        end
        if (bytes_left_d == '0) begin
          frag_d  = 1'b0;
          stamp_d = stamp_adv;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result queue: entry 0 is the head and drives the output.
  // The input register advances only if three free entries remain.
  // ---------------------------------------------------------------------
  h264rtp_pkg::out_item_t         que_q     [h264rtp_pkg::QUEUE_DEPTH];
  h264rtp_pkg::out_item_t         que_d     [h264rtp_pkg::QUEUE_DEPTH];
  h264rtp_pkg::out_item_t         que_shift [h264rtp_pkg::QUEUE_DEPTH];
  logic [h264rtp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [h264rtp_pkg::CNT_W-1:0]  keep;
  logic [h264rtp_pkg::CNT_W-1:0]  slot;
  logic                           pop;

  assign pkt_o.valid   = (cnt_q != '0);
  assign pkt_o.payload = que_q[0];
  assign pop           = pkt_o.valid && pkt_o.ready;
  assign keep          = cnt_q - h264rtp_pkg::CNT_W'(pop);
  assign fire          = stg_valid_q && (keep <= h264rtp_pkg::CNT_W'(1));

  always_comb begin
    for (int i = 0; i < h264rtp_pkg::QUEUE_DEPTH - 1; i++) begin
      que_shift[i] = pop ? que_q[i+1] : que_q[i];
    end
    que_shift[h264rtp_pkg::QUEUE_DEPTH-1] = que_q[h264rtp_pkg::QUEUE_DEPTH-1];

    slot = '0;
    for (int i = 0; i < h264rtp_pkg::QUEUE_DEPTH; i++) begin
      slot = h264rtp_pkg::CNT_W'(i) - keep;
      if (h264rtp_pkg::CNT_W'(i) < keep) begin
        que_d[i] = que_shift[i];
      end else if (fire && (slot < {1'b0, n_res})) begin
        que_d[i] = res[slot[1:0]];
      end else begin
        que_d[i] = que_q[i];
      end
    end

    cnt_d = keep + (fire ? {1'b0, n_res} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < h264rtp_pkg::QUEUE_DEPTH; i++) begin
      que_q[i] <= que_d[i];
    end
  end

endmodule

[hw/rtl/h264rtp_checker.sv]
// Port-level checks of the packetizer core, bound to its top level.
// Depends on h264rtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module h264rtp_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input h264rtp_pkg::out_item_t out_item_i
);

  logic                                             out_acc;
  logic                                             out_wait;
  logic                                             out_open;
  logic                                             out_end;
  logic                                             out_cont;
  logic [h264rtp_pkg::SEQ_W+h264rtp_pkg::TS_W-1:0] out_tag;

  assign out_acc  = out_valid_i && out_ready_i;
  assign out_wait = out_valid_i && !out_ready_i;
  assign out_open = out_acc && !out_item_i.packet_last;
  assign out_end  = out_acc && out_item_i.packet_last;
  assign out_cont = out_acc && !out_item_i.packet_first;
  assign out_tag  = {out_item_i.seq_number, out_item_i.time_stamp};

  // a stalled result holds
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_i && $stable(out_item_i))

  // input only stalls behind queued results
  `CHK_ASSERT_ALWAYS(a_stall_has_backlog, clk_i, !in_ready_i |-> out_valid_i)

  // a byte that continues a packet keeps its sequence number and timestamp
  `CHK_ASSERT(a_pkt_same_tag, clk_i, rst_ni, out_open ##1 out_cont |-> $stable(out_tag))

  // after a packet ends, the next byte starts a new one
  `CHK_ASSERT(a_pkt_boundary, clk_i, rst_ni, out_end ##1 out_acc |-> out_item_i.packet_first)

endmodule

bind h264_nal_rtp_packetizer_core h264rtp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (nal_i.ready),
  .out_valid_i (pkt_o.valid),
  .out_ready_i (pkt_o.ready),
  .out_item_i  (pkt_o.payload)
);

[tb/h264_nal_rtp_packetizer_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for h264_nal_rtp_packetizer_core: NAL bytes in, RTP payload out.
// Depends on h264rtp_pkg, the three channel interfaces and the core.
module h264_nal_rtp_packetizer_core_test;

  // Percent of cycles in which either side idles while in random mode.
  localparam int unsigned IDLE_PCT = 26;
  // Long output hold-off used to fill the block and stall its input.
  localparam int unsigned HOLD_CYCLES = 300;
  // Extra wait after draining, before touching registers.
  localparam int unsigned SETTLE_CYCLES = 6;
  // Longest correct stretch without any request is the hold-off above,
  // plus the short random stalls on top.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;

  h264rtp_nal_if nal_bus ();
  h264rtp_pkt_if pkt_bus ();
  h264rtp_cfg_if cfg_bus ();

  h264_nal_rtp_packetizer_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .nal_i (nal_bus),
    .pkt_o (pkt_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Packetizer shadow: register copies and state of the NAL being cut up.
  // ---------------------------------------------------------------------------
  logic [h264rtp_pkg::MAXP_W-1:0] cfg_max_payload;
  logic [h264rtp_pkg::STEP_W-1:0] cfg_time_step;
  logic [h264rtp_pkg::LEN_W-1:0]  body_remaining;  // NAL bytes still to arrive
  logic [h264rtp_pkg::MAXP_W-1:0] frag_count;      // body bytes in the open fragment
  logic [h264rtp_pkg::BYTE_W-1:0] held_header;     // NAL header byte, source of FU bytes
  logic                           fu_mode;         // NAL is being sent as FU-A fragments
  logic                           start_pending;   // next fragment carries the start bit
  logic [h264rtp_pkg::SEQ_W-1:0]  seq_now;
  logic [h264rtp_pkg::TS_W-1:0]   rtp_time;

  h264rtp_pkg::out_item_t expected_payload[$];
  int unsigned mismatches = 0;

  // Traffic shaping shared with the output side.
  bit          steady_flow = 1'b0;
  int unsigned holds_requested = 0;

  function automatic void push_payload(input logic [7:0] value, input logic first,
                                       input logic last);
    h264rtp_pkg::out_item_t item;
    item.payload_byte = value;
    item.packet_first = first;
    item.packet_last  = last;
    item.seq_number   = seq_now;
    item.time_stamp   = rtp_time;
    expected_payload.push_back(item);
  endfunction

  // Single-packet NAL done: packet closes; SPS/PPS keep the timestamp.
  function automatic void close_single_nal();
    seq_now++;
    if (held_header[4:0] != h264rtp_pkg::NAL_TYPE_SPS &&
        held_header[4:0] != h264rtp_pkg::NAL_TYPE_PPS)
      rtp_time += cfg_time_step;
  endfunction

  // Expected payload bytes for one accepted NAL byte request.
  function automatic void packetize_byte(input h264rtp_pkg::in_item_t req);
    logic [h264rtp_pkg::LEN_W:0]    nal_len;
    logic [h264rtp_pkg::MAXP_W-1:0] cap;
    logic [7:0]                     fu_header;
    logic                           closes_packet;
    cap = (cfg_max_payload == '0) ? h264rtp_pkg::MAXP_W'(1) : cfg_max_payload;
    if (req.nal_first) begin
      // restart abandons the old NAL; an open packet of it still uses a number
      if (body_remaining != '0 && (!fu_mode || frag_count != '0))
        seq_now++;
      nal_len = {1'b0, req.nal_length};
      if (nal_len == '0)
        nal_len = (h264rtp_pkg::LEN_W+1)'(1);
      if (nal_len > {1'b0, h264rtp_pkg::MAX_NAL_BYTES})
        nal_len = {1'b0, h264rtp_pkg::MAX_NAL_BYTES};
      held_header    = req.data_byte;
      frag_count     = '0;
      body_remaining = h264rtp_pkg::LEN_W'(nal_len - 1);
      if (nal_len <= cap) begin
        fu_mode       = 1'b0;
        start_pending = 1'b0;
        push_payload(req.data_byte, 1'b1, body_remaining == '0);
        if (body_remaining == '0)
          close_single_nal();
      end else begin
        // header byte is consumed; it only feeds the FU indicator/header
        fu_mode       = 1'b1;
        start_pending = 1'b1;
      end
    end else if (body_remaining != '0) begin
      if (!fu_mode) begin
        body_remaining--;
        push_payload(req.data_byte, 1'b0, body_remaining == '0);
        if (body_remaining == '0)
          close_single_nal();
      end else begin
        if (frag_count == '0) begin
          fu_header = (held_header & h264rtp_pkg::TYPE_MASK)
                    | (start_pending ? h264rtp_pkg::FU_START_BIT : 8'h00)
                    | ((body_remaining <= cap) ? h264rtp_pkg::FU_END_BIT : 8'h00);
          start_pending = 1'b0;
          push_payload((held_header & h264rtp_pkg::NRI_MASK) | h264rtp_pkg::FU_A_TYPE,
                       1'b1, 1'b0);
          push_payload(fu_header, 1'b0, 1'b0);
        end
        body_remaining--;
        frag_count++;
        closes_packet = (frag_count >= cap) || (body_remaining == '0);
        push_payload(req.data_byte, 1'b0, closes_packet);
        if (closes_packet) begin
          frag_count = '0;
          seq_now++;
        end
        if (body_remaining == '0) begin
          fu_mode = 1'b0;
          rtp_time += cfg_time_step;
        end
      end
    end
    // stray byte with no NAL open: nothing
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random ready, steady mode, and long hold-offs on request.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_count;
    int unsigned holds_granted;
    hold_count    = 0;
    holds_granted = 0;
    pkt_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        pkt_bus.ready <= 1'b0;
      end else if (holds_granted != holds_requested) begin
        holds_granted = holds_requested;
        hold_count    = HOLD_CYCLES;
        pkt_bus.ready <= 1'b0;
      end else if (hold_count != 0) begin
        hold_count--;
        pkt_bus.ready <= 1'b0;
      end else begin
        pkt_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each payload request against the oldest expectation.
  h264rtp_pkg::out_item_t want;
  h264rtp_pkg::out_item_t got;
  always @(posedge clk) begin
    if (rst_n && pkt_bus.valid && pkt_bus.ready) begin
      got = pkt_bus.payload;
      if (expected_payload.size() == 0) begin
        $error("payload_byte: expected none, actual %0h", got.payload_byte);
        mismatches++;
      end else begin
        want = expected_payload.pop_front();
        if (got.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
          mismatches++;
        end
        if (got.packet_first !== want.packet_first) begin
          $error("packet_first: expected %0b, actual %0b", want.packet_first, got.packet_first);
          mismatches++;
        end
        if (got.packet_last !== want.packet_last) begin
          $error("packet_last: expected %0b, actual %0b", want.packet_last, got.packet_last);
          mismatches++;
        end
        if (got.seq_number !== want.seq_number) begin
          $error("seq_number: expected %0d, actual %0d", want.seq_number, got.seq_number);
          mismatches++;
        end
        if (got.time_stamp !== want.time_stamp) begin
          $error("time_stamp: expected %0d, actual %0d", want.time_stamp, got.time_stamp);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any request on any channel ends the run.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (nal_bus.valid && nal_bus.ready) || (pkt_bus.valid && pkt_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("h264_nal_rtp_packetizer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers.
  // ---------------------------------------------------------------------------

  // Offer one NAL byte request; valid stays high afterward so back-to-back
  // requests never drop it within a time step.
  task automatic send_nal_byte(input logic [7:0] value, input logic first,
                               input logic [h264rtp_pkg::LEN_W-1:0] len_field);
    h264rtp_pkg::in_item_t req;
    req.data_byte  = value;
    req.nal_first  = first;
    req.nal_length = len_field;
    if (!steady_flow)
      while ($urandom_range(99) < IDLE_PCT) begin
        nal_bus.valid <= 1'b0;
        @(posedge clk);
      end
    nal_bus.valid   <= 1'b1;
    nal_bus.payload <= req;
    do @(posedge clk); while (!nal_bus.ready);
    packetize_byte(req);
  endtask

  // Header byte with the given length field, then random body bytes.
  task automatic send_nal(input logic [7:0] header,
                          input logic [h264rtp_pkg::LEN_W-1:0] len_field,
                          input int unsigned byte_count);
    send_nal_byte(header, 1'b1, len_field);
    for (int unsigned i = 1; i < byte_count; i++)
      send_nal_byte(8'($urandom), 1'b0, h264rtp_pkg::LEN_W'($urandom));
  endtask

  // Drop valid, wait out all expected bytes plus the core's latency.
  task automatic drain_results();
    nal_bus.valid <= 1'b0;
    while (expected_payload.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers back to back; only called with the core drained.
  task automatic write_config(input int unsigned cap_bytes, input int unsigned step_ticks);
    h264rtp_pkg::cfg_req_t req;
    req.index = h264rtp_pkg::REG_MAX_PAYLOAD;
    req.data  = h264rtp_pkg::STEP_W'(cap_bytes);
    cfg_bus.valid   <= 1'b1;
    cfg_bus.payload <= req;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_max_payload = h264rtp_pkg::MAXP_W'(cap_bytes);
    req.index = h264rtp_pkg::REG_TIMESTAMP_STEP;
    req.data  = h264rtp_pkg::STEP_W'(step_ticks);
    cfg_bus.payload <= req;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_time_step = h264rtp_pkg::STEP_W'(step_ticks);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset registers: short NALs go out whole; SPS/PPS hold the timestamp.
  task automatic test_single_packets();
    send_nal(8'h65, 21'd1, 1);
    send_nal(8'h67, 21'd3, 3);
    send_nal(8'h68, 21'd2, 2);
    send_nal(8'hFF, 21'd0, 1);   // zero length taken as one byte
    send_nal(8'h00, 21'd2, 2);
    drain_results();
  endtask

  // Tiny payload limits: zero acts as one; a lone fragment gets both bits;
  // a fragmented SPS still advances the timestamp.
  task automatic test_fragmentation();
    write_config(0, 131071);
    send_nal(8'hC5, 21'd3, 3);
    drain_results();
    write_config(2, 90000);
    send_nal(8'h67, 21'd3, 3);
    drain_results();
  endtask

  // Stray byte, and restarts at every point of an unfinished NAL.
  task automatic test_broken_sequences();
    send_nal_byte(8'hAA, 1'b0, 21'd5);   // no NAL open: ignored
    send_nal(8'h41, 21'd2, 1);           // open single packet
    send_nal(8'h61, 21'd4, 1);           // restart closes it; header only
    send_nal(8'h41, 21'd6, 2);           // restart before any fragment
    send_nal(8'h45, 21'd5, 3);           // restart mid fragment, ends on boundary
    send_nal(8'h25, 21'h1FFFFF, 3);      // restart on boundary; length saturates
    send_nal(8'h09, 21'd1, 1);           // restart on boundary again
    drain_results();
  endtask

  // One register setting, then mostly well-formed NALs with random content
  // and some noise: strays, truncation, zero and oversized lengths.
  task automatic run_traffic_phase(input int unsigned cap_bytes, input int unsigned step_ticks,
                                   input int unsigned nal_count, input int unsigned max_len);
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    logic [7:0]  hdr;
    write_config(cap_bytes, step_ticks);
    cap = (cap_bytes == 0) ? 1 : cap_bytes;
    repeat (nal_count) begin
      pick = $urandom_range(99);
      hdr  = 8'($urandom);
      len  = $urandom_range(max_len, 1);
      if (pick < 6)
        send_nal_byte(hdr, 1'b0, h264rtp_pkg::LEN_W'($urandom));
      else if (pick < 12)
        send_nal(hdr, h264rtp_pkg::LEN_W'(len + 1), $urandom_range(len, 1));
      else if (pick < 16)
        send_nal(hdr, '0, 1);
      else if (pick < 19)
        send_nal(hdr, h264rtp_pkg::LEN_W'($urandom_range(2097151, 1048577)),
                 $urandom_range(8, 1));
      else if (pick < 28)
        send_nal({hdr[7:5], pick[0] ? h264rtp_pkg::NAL_TYPE_SPS : h264rtp_pkg::NAL_TYPE_PPS},
                 h264rtp_pkg::LEN_W'(len), len);
      else if (pick < 40 && cap <= 64) begin
        // around the fragmentation and fragment-size boundaries
        len = cap + $urandom_range(cap + 1);
        send_nal(hdr, h264rtp_pkg::LEN_W'(len), len);
      end else
        send_nal(hdr, h264rtp_pkg::LEN_W'(len), len);
    end
    // finish the phase on a complete NAL so nothing is left open
    len = $urandom_range(max_len, 1);
    send_nal(8'($urandom), h264rtp_pkg::LEN_W'(len), len);
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(16, 90000, 4, 26);
    run_traffic_phase(20, 0, 3, 30);
    run_traffic_phase(0, 3600, 8, 5);
    run_traffic_phase(2047, 131071, 3, 16);
    run_traffic_phase(1500, 131071, 1, 12);
  endtask

  // No idling on either side, then a long output hold-off while input keeps
  // coming, so the result queue fills and input requests stall.
  task automatic test_backpressure();
    write_config(16, 1);
    steady_flow = 1'b1;
    send_nal(8'h7C, 21'd12, 12);
    send_nal(8'h21, 21'd12, 12);
    holds_requested++;
    send_nal(8'h41, 21'd24, 24);
    steady_flow = 1'b0;
    drain_results();
  endtask

  initial begin
    nal_bus.valid   = 1'b0;
    nal_bus.payload = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.payload = '0;
    rst_n           = 1'b0;

    cfg_max_payload = h264rtp_pkg::MAX_PAYLOAD_RST;
    cfg_time_step   = h264rtp_pkg::TIMESTAMP_STEP_RST;
    body_remaining  = '0;
    frag_count      = '0;
    held_header     = '0;
    fu_mode         = 1'b0;
    start_pending   = 1'b0;
    seq_now         = '0;
    rtp_time        = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_single_packets();
    test_fragmentation();
    test_broken_sequences();
    test_random_traffic();
    test_backpressure();

    if (mismatches == 0)
      $display("h264_nal_rtp_packetizer_core verification clean");
    else
      $display("h264_nal_rtp_packetizer_core verification failed");
    $finish;
  end

endmodule
